// ----- rtl/rsort_pkg.sv -----
package rsort_pkg;

  localparam int unsigned MAX_RECORDS  = 64;
  localparam int unsigned KEY_BITS     = 16;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam int unsigned CNT_W        = $clog2(MAX_RECORDS + 1);

  typedef logic [KEY_BITS-1:0]     key_t;
  typedef logic [PAYLOAD_BITS-1:0] pld_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_e;

  // Commands broadcast along the chain of cells.
  typedef struct packed {
    logic load;   // insert the incoming record
    logic shift;  // move every record one cell towards the head
  } cell_cmd_t;

endpackage

// ----- rtl/rsort_cell.sv -----
module rsort_cell
  import rsort_pkg::*;
(
  input  logic      clk_i,
  input  cell_cmd_t cmd_i,
  input  logic      occupied_i,
  input  key_t      new_key_i,
  input  pld_t      new_payload_i,
  input  logic      prev_ins_i,
  input  key_t      prev_key_i,
  input  pld_t      prev_payload_i,
  input  key_t      next_key_i,
  input  pld_t      next_payload_i,
  output logic      ins_o,
  output key_t      key_o,
  output pld_t      payload_o
);

  key_t key_q, key_d;
  pld_t payload_q, payload_d;

  // A strict compare keeps equal keys in arrival order.
  assign ins_o = !occupied_i || (key_q > new_key_i);

  always_comb begin
    key_d     = key_q;
    payload_d = payload_q;
    if (cmd_i.shift) begin
      key_d     = next_key_i;
      payload_d = next_payload_i;
    end else if (cmd_i.load && ins_o) begin
      if (prev_ins_i) begin
        key_d     = prev_key_i;
        payload_d = prev_payload_i;
      end else begin
        key_d     = new_key_i;
        payload_d = new_payload_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

  assign key_o     = key_q;
  assign payload_o = payload_q;

endmodule

// ----- rtl/rsort_ctrl.sv -----
module rsort_ctrl
  import rsort_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      last_in_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output logic      last_out_o,
  output logic      overflow_o,
  output cnt_t      count_o,
  output cell_cmd_t cmd_o
);

  state_e state_q, state_d;
  cnt_t   count_q, count_d;
  logic   dropped_q, dropped_d;
  logic   in_xfer, out_xfer, full;

  assign full     = (count_q == CNT_W'(MAX_RECORDS));
  assign in_xfer  = in_valid_i && (state_q == ST_LOAD);
  assign out_xfer = (state_q == ST_EMIT) && !out_stall_i;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    cmd_o     = '0;
    unique case (state_q)
      ST_LOAD: begin
        if (in_xfer) begin
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            count_d    = count_q + 1'b1;
          end
          if (last_in_i) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_xfer) begin
          cmd_o.shift = 1'b1;
          count_d     = count_q - 1'b1;
          if (count_q == CNT_W'(1)) begin
            state_d   = ST_LOAD;
            dropped_d = 1'b0;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
    end
  end

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = (state_q == ST_EMIT);
  assign last_out_o  = (count_q == CNT_W'(1));
  assign overflow_o  = dropped_q;
  assign count_o     = count_q;

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_q != '0)
    else $error("emitting with no stored records");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RECORDS))
    else $error("record count beyond capacity");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !last_in_i && !full) |=> count_q == CNT_W'($past(count_q) + 1'b1))
    else $error("insertion did not advance the count");

  a_set_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && last_out_o) |=> (state_q == ST_LOAD && count_q == '0 && !dropped_q))
    else $error("block not cleared after the final transfer");

endmodule

// ----- rtl/record_insertion_sorter.sv -----
// Record insertion sorter.
// Input channel: sort_key_i, payload_i and last_in_i with in_valid_i; the
// block drives in_stall_o. Output channel: out_key_o, out_payload_o,
// last_out_o and overflow_o with out_valid_o; the receiver drives out_stall_i.
// While loading, one record is taken every cycle; it is inserted into a chain
// of cells, each holding one record, by a shift of the cells whose keys are
// greater. Equal keys keep their arrival order.
// The transfer that carries last_in_i closes the set. From the next cycle the
// stored records leave in ascending key order, one per cycle while the
// receiver does not stall, the chain moving one cell towards its head on
// every output transfer; last_out_o marks the final record. No input is taken
// during the emit phase. A stall holds the head record on the outputs. Records
// arriving with the chain full are dropped and overflow_o is high on every
// record of that set. Reset empties the chain at once.
module record_insertion_sorter
  import rsort_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  key_t sort_key_i,
  input  pld_t payload_i,
  input  logic last_in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output key_t out_key_o,
  output pld_t out_payload_o,
  output logic last_out_o,
  output logic overflow_o
);

  cell_cmd_t cmd;
  cnt_t      count;

  logic ins   [MAX_RECORDS];
  key_t keys  [MAX_RECORDS];
  pld_t plds  [MAX_RECORDS];

  rsort_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_in_i   (last_in_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .last_out_o  (last_out_o),
    .overflow_o  (overflow_o),
    .count_o     (count),
    .cmd_o       (cmd)
  );

  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    logic occupied;
    logic prev_ins;
    key_t prev_key, next_key;
    pld_t prev_pld, next_pld;

    assign occupied = (count > CNT_W'(i));

    if (i == 0) begin : g_head
      assign prev_ins = 1'b0;
      assign prev_key = sort_key_i;
      assign prev_pld = payload_i;
    end else begin : g_body
      assign prev_ins = ins[i-1];
      assign prev_key = keys[i-1];
      assign prev_pld = plds[i-1];
    end

    // The tail cell refills with don't-care data when the chain shifts.
    if (i == MAX_RECORDS - 1) begin : g_tail
      assign next_key = sort_key_i;
      assign next_pld = payload_i;
    end else begin : g_inner
      assign next_key = keys[i+1];
      assign next_pld = plds[i+1];
    end

    rsort_cell u_cell (
      .clk_i          (clk_i),
      .cmd_i          (cmd),
      .occupied_i     (occupied),
      .new_key_i      (sort_key_i),
      .new_payload_i  (payload_i),
      .prev_ins_i     (prev_ins),
      .prev_key_i     (prev_key),
      .prev_payload_i (prev_pld),
      .next_key_i     (next_key),
      .next_payload_i (next_pld),
      .ins_o          (ins[i]),
      .key_o          (keys[i]),
      .payload_o      (plds[i])
    );
  end

  assign out_key_o     = keys[0];
  assign out_payload_o = plds[0];

endmodule
